>>> hw/rtl/ramt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ramt_pkg: shared types and codes of the range-add / range-min tree
// Value and index types, command codes, the packed tree node word and the
// signed minimum used when subtree minima are combined.
// ----------------------------------------------------------------------------
package ramt_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned IDX_W = 11;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [IDX_W-1:0]        t_idx;

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // one tree node as stored in memory
    typedef struct packed {
        t_val pend;
        t_val smin;
    } t_node;

    function automatic t_val min_s(t_val p, t_val q);
        return (p <= q) ? p : q;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ramt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ramt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ramt_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2047,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/range_add_range_min_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_add_range_min_tree: range add / range minimum over a lazy tree
// Holds LEAVES signed 32-bit elements as a heap of pending adds and subtree
// minima in one node RAM, walked level by level by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. i_command selects add (addend over [start, end)) or query
//   (minimum over [start, end)). Bounds past LEAVES are clamped.
//   Result channel: a query returns one transaction; o_result_valid is high
//   for exactly one cycle with o_min_value and o_range_empty. An add returns
//   nothing. The receiver cannot stall; results are never held.
// Sequencing:
//   Empty range: done at once; a query result shows the cycle after accept.
//   Otherwise the tree is walked bottom-up, LEVELS = log2(P) levels with P the
//   leaf count rounded up to a power of two. Each level passes the check state
//   LEVEL, then RD0, RD1, RDN and FIN for each boundary node (at most two per
//   level, one at the root), as the node RAM has a single read port; a fully
//   covered root adds ROOT_RD and ROOT_WB. A query result shows in the first
//   cycle busy is low.
// Reset:
//   After reset the node RAM is cleared one node per cycle, all 2*P-1 nodes
//   (2047 for 1024 leaves), with busy high; then the block goes idle.
// ----------------------------------------------------------------------------
module range_add_range_min_tree
    import ramt_pkg::*;
#(
    parameter int unsigned LEAVES = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic i_command,
    input  wire t_idx i_range_start,
    input  wire t_idx i_range_end,
    input  wire t_val i_addend,
    output logic      busy,
    output logic      o_result_valid,
    output t_val      o_min_value,
    output logic      o_range_empty
);

    localparam int unsigned TREE_P = 2 ** $clog2(LEAVES);
    localparam int unsigned LEVELS = $clog2(TREE_P);
    localparam int unsigned NODES  = 2 * TREE_P - 1;
    localparam int unsigned PW     = LEVELS + 1;   // positions 0..P and node addresses
    localparam int unsigned CW     = (PW > IDX_W) ? PW : IDX_W;

    localparam logic [CW-1:0] LIM_C     = CW'(LEAVES);
    localparam logic [PW-1:0] LEAVES_P  = PW'(LEAVES);
    localparam logic [PW-1:0] TREE_P_P  = PW'(TREE_P);
    localparam logic [PW-1:0] BASE_INIT = PW'(TREE_P >> 1);
    localparam logic [PW-1:0] LAST_NODE = PW'(NODES - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEVEL,
        ST_RD0,
        ST_RD1,
        ST_RDN,
        ST_FIN,
        ST_ROOT_RD,
        ST_ROOT_WB
    } t_state;

    t_state          r_state;
    logic            r_cmd;
    logic [PW-1:0]   r_a;       // clamped start
    logic [PW-1:0]   r_b;       // clamped end
    logic [PW-1:0]   r_bm1;     // clamped end minus one
    t_val            r_x;
    logic [PW-1:0]   r_mask;    // span of a node at this level, minus one
    logic [PW-1:0]   r_base;    // heap offset of this level, plus one
    logic [PW-1:0]   r_nl;      // left boundary node index within level
    logic [PW-1:0]   r_nr;      // right boundary node index within level
    logic            r_side;    // 0 = left boundary node, 1 = right
    t_val            r_acc_l;
    t_val            r_acc_r;
    t_val            r_v0;
    t_val            r_v1;
    logic [PW-1:0]   r_clr_addr;
    logic            r_out_valid;
    t_val            r_out_min;
    logic            r_out_empty;

    // ---- clamp the incoming bounds ----
    logic [CW-1:0] a_ext, b_ext;
    logic [PW-1:0] a_in, b_in, bm1_in;

    assign a_ext  = (CW'(i_range_start) > LIM_C) ? LIM_C : CW'(i_range_start);
    assign b_ext  = (CW'(i_range_end)   > LIM_C) ? LIM_C : CW'(i_range_end);
    assign a_in   = a_ext[PW-1:0];
    assign b_in   = b_ext[PW-1:0];
    assign bm1_in = b_in - PW'(1);

    // ---- geometry of the current level and node ----
    logic [PW-1:0] width_w, half_w, start_l, start_r, cur_start, cur_n;
    logic [PW-1:0] mid, node_end, prev_start_l;
    logic          part_l, part_r, distinct, at_top, root_cov;
    logic          c0_cov, c0_over, c1_cov, c1_over, c1_in;
    logic [PW-1:0] t_sum, k_node, k_c0, k_c1;
    logic [PW:0]   t_dbl;

    assign width_w   = r_mask + PW'(1);
    assign half_w    = (r_mask >> 1) + PW'(1);
    assign start_l   = r_a & ~r_mask;
    assign start_r   = r_bm1 & ~r_mask;
    // a boundary node always overlaps the range; it is partial unless contained
    assign part_l    = (r_a != start_l) || ((start_l + width_w) > r_b);
    assign part_r    = (r_a > start_r)  || ((start_r + width_w) > r_b);
    assign distinct  = (r_nl != r_nr);
    assign at_top    = (r_base == PW'(1));
    assign root_cov  = (r_a == '0) && (r_b == TREE_P_P);

    assign cur_start = r_side ? start_r : start_l;
    assign cur_n     = r_side ? r_nr : r_nl;
    assign mid       = cur_start + half_w;
    assign node_end  = cur_start + width_w;
    assign prev_start_l = r_a & ~(r_mask >> 1);

    assign c0_over   = (r_a < mid);
    assign c0_cov    = (r_a <= cur_start) && (mid <= r_b);
    assign c1_in     = (mid < LEAVES_P);
    assign c1_over   = (mid < r_b);
    assign c1_cov    = (r_a <= mid) && (node_end <= r_b);

    // heap addresses: node = base+n-1, children = 2(base+n)-1 and 2(base+n)
    assign t_sum  = r_base + cur_n;
    assign k_node = t_sum - PW'(1);
    assign t_dbl  = {t_sum, 1'b0};
    assign k_c1   = t_dbl[PW-1:0];
    assign k_c0   = k_c1 - PW'(1);

    // ---- node RAM ----
    logic            ram_we;
    logic [PW-1:0]   ram_waddr, ram_raddr;
    t_node           ram_wdata, rd_node;
    logic [2*VAL_W-1:0] ram_rdata;

    ramt_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_node = ram_rdata;

    // ---- shared child / node arithmetic ----
    logic          ch_cov, ch_part;
    logic [PW-1:0] ch_start;
    t_val          ch_acc, ch_pend_new, nv_rd, ch_val;
    t_val          v_min, fin_sel, fin_acc;

    assign nv_rd       = rd_node.pend + rd_node.smin;
    assign ch_pend_new = rd_node.pend + r_x;
    assign ch_start    = (r_state == ST_RD1) ? cur_start : mid;
    assign ch_cov      = (r_state == ST_RD1) ? c0_cov : c1_cov;
    assign ch_part     = (r_state == ST_RD1) ? (c0_over && !c0_cov) : (c1_over && !c1_cov);
    // a partial child was a boundary node of the level below
    assign ch_acc      = (ch_start == prev_start_l) ? r_acc_l : r_acc_r;

    always_comb begin
        if (r_cmd == CMD_ADD && ch_cov) begin
            ch_val = ch_pend_new + rd_node.smin;
        end else if (ch_part) begin
            ch_val = ch_acc;
        end else begin
            ch_val = nv_rd;
        end
    end

    assign v_min = min_s(r_v0, r_v1);

    always_comb begin
        if (r_cmd == CMD_ADD) begin
            // a right child past the last element does not count
            fin_sel = c1_in ? v_min : r_v0;
        end else if (c0_over && c1_over) begin
            fin_sel = v_min;
        end else if (c0_over) begin
            fin_sel = r_v0;
        end else begin
            fin_sel = r_v1;
        end
    end

    assign fin_acc = fin_sel + rd_node.pend;

    // ---- RAM port control ----
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_node;
        ram_wdata = '{pend: rd_node.pend, smin: fin_sel};
        ram_raddr = k_node;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            ST_RD0: begin
                ram_raddr = k_c0;
            end
            ST_RD1: begin
                ram_raddr = k_c1;
                ram_we    = (r_cmd == CMD_ADD) && c0_cov;
                ram_waddr = k_c0;
                ram_wdata = '{pend: ch_pend_new, smin: rd_node.smin};
            end
            ST_RDN: begin
                ram_raddr = k_node;
                ram_we    = (r_cmd == CMD_ADD) && c1_cov;
                ram_waddr = k_c1;
                ram_wdata = '{pend: ch_pend_new, smin: rd_node.smin};
            end
            ST_FIN: begin
                ram_we    = (r_cmd == CMD_ADD);
            end
            ST_ROOT_RD: begin
                ram_raddr = '0;
            end
            ST_ROOT_WB: begin
                ram_we    = (r_cmd == CMD_ADD);
                ram_waddr = '0;
                ram_wdata = '{pend: ch_pend_new, smin: rd_node.smin};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_out_empty <= 1'b0;
            r_side      <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    // sweep every node to zero before taking commands
                    r_clr_addr <= r_clr_addr + PW'(1);
                    if (r_clr_addr == LAST_NODE) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_cmd  <= i_command;
                        r_a    <= a_in;
                        r_b    <= b_in;
                        r_bm1  <= bm1_in;
                        r_x    <= i_addend;
                        r_mask <= PW'(1);
                        r_base <= BASE_INIT;
                        r_nl   <= a_in >> 1;
                        r_nr   <= bm1_in >> 1;
                        r_side <= 1'b0;
                        if (a_in < b_in) begin
                            r_state <= ST_LEVEL;
                        end else if (i_command == CMD_QUERY) begin
                            // empty range: answer at once
                            r_out_valid <= 1'b1;
                            r_out_min   <= '0;
                            r_out_empty <= 1'b1;
                        end
                    end
                end
                ST_LEVEL: begin
                    if (part_l) begin
                        r_side  <= 1'b0;
                        r_state <= ST_RD0;
                    end else if (distinct && part_r) begin
                        r_side  <= 1'b1;
                        r_state <= ST_RD0;
                    end else if (at_top) begin
                        // root fully inside the range
                        r_state <= ST_ROOT_RD;
                    end else begin
                        r_mask  <= {r_mask[PW-2:0], 1'b1};
                        r_base  <= r_base >> 1;
                        r_nl    <= r_nl >> 1;
                        r_nr    <= r_nr >> 1;
                        r_side  <= 1'b0;
                    end
                end
                ST_RD0: begin
                    r_state <= ST_RD1;
                end
                ST_RD1: begin
                    r_v0    <= ch_val;
                    r_state <= ST_RDN;
                end
                ST_RDN: begin
                    r_v1    <= ch_val;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_side) begin
                        r_acc_r <= fin_acc;
                    end else begin
                        r_acc_l <= fin_acc;
                    end
                    if (!r_side && distinct && part_r) begin
                        r_side  <= 1'b1;
                        r_state <= ST_RD0;
                    end else if (at_top) begin
                        // root was the last boundary node: its value is the answer
                        r_state <= ST_IDLE;
                        if (r_cmd == CMD_QUERY) begin
                            r_out_valid <= 1'b1;
                            r_out_min   <= fin_acc;
                            r_out_empty <= 1'b0;
                        end
                    end else begin
                        r_mask  <= {r_mask[PW-2:0], 1'b1};
                        r_base  <= r_base >> 1;
                        r_nl    <= r_nl >> 1;
                        r_nr    <= r_nr >> 1;
                        r_side  <= 1'b0;
                        r_state <= ST_LEVEL;
                    end
                end
                ST_ROOT_RD: begin
                    r_state <= ST_ROOT_WB;
                end
                ST_ROOT_WB: begin
                    r_state <= ST_IDLE;
                    if (r_cmd == CMD_QUERY && root_cov) begin
                        r_out_valid <= 1'b1;
                        r_out_min   <= nv_rd;
                        r_out_empty <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_min_value    = r_out_min;
    assign o_range_empty  = r_out_empty;

endmodule
`default_nettype wire

>>> hw/rtl/ramt_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ramt_check: port-level checks for the range-add / range-min tree
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ramt_check
    import ramt_pkg::*;
#(
    parameter int unsigned LEAVES = 1024
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic i_command,
    input wire t_idx i_range_start,
    input wire t_idx i_range_end,
    input wire logic busy,
    input wire logic o_result_valid,
    input wire t_val o_min_value,
    input wire logic o_range_empty
);

    logic accept;
    assign accept = start && !busy;

    // the clearing sweep keeps the block busy right after reset
    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy after reset");

    // an empty query answers in the next cycle with the empty flag and zero
    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_QUERY && i_range_start >= i_range_end)
        |=> (o_result_valid && o_range_empty && o_min_value == '0))
        else $error("empty query not answered at once");

    // an accepted add is never followed at once by a result transaction
    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_ADD) |=> !o_result_valid)
        else $error("result after add");

    // a nonempty command (start below LEAVES) makes the block busy right after it is accepted
    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_range_start < i_range_end && 32'(i_range_start) < LEAVES)
        |=> busy)
        else $error("nonempty command did not occupy the block");

    // results only leave when the sequencer has finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result while busy");

endmodule

bind range_add_range_min_tree ramt_check #(
    .LEAVES (LEAVES)
) u_ramt_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .i_command      (i_command),
    .i_range_start  (i_range_start),
    .i_range_end    (i_range_end),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_min_value    (o_min_value),
    .o_range_empty  (o_range_empty)
);
`default_nettype wire
